// ===== hw/rtl/slcp_pkg.sv =====
// Package for the serial LCD command parser: parse modes, action codes,
// control handshake structs and the high-byte character substitution table.
// No dependencies.
`default_nettype none

package slcp_pkg;

	localparam int LINE_LENGTH_DEF = 20;

	localparam logic [7:0] CH_STX    = 8'h02;
	localparam logic [7:0] CH_ETX    = 8'h03;
	localparam logic [7:0] CH_HELLO  = 8'h68;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_PIPE   = 8'h7C;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_ONE    = 8'h31;
	localparam logic [7:0] CH_Z      = 8'h5A;
	localparam logic [7:0] CH_L      = 8'h4C;
	localparam logic [7:0] CH_C      = 8'h43;
	localparam logic [7:0] CH_M      = 8'h4D;
	localparam logic [7:0] CH_S      = 8'h53;
	localparam logic [7:0] NO_MATCH  = 8'hB0;
	localparam logic [7:0] ASCII_MAX = 8'd127;
	localparam logic [7:0] COL_MAX   = 8'd19;

	typedef enum logic [3:0] {
		M_STX   = 4'd1,
		M_CMD   = 4'd2,
		M_LED   = 4'd3,
		M_ROW   = 4'd4,
		M_SPACE = 4'd5,
		M_TEXT  = 4'd6,
		M_CUREN = 4'd8,
		M_COL1  = 4'd9,
		M_COL2  = 4'd10,
		M_SEP   = 4'd11,
		M_CROW  = 4'd12,
		M_SS    = 4'd13
	} mode_t;

	typedef enum logic [2:0] {
		A_HELLO  = 3'd0,
		A_CLEAR  = 3'd1,
		A_GOTO   = 3'd2,
		A_COFF   = 3'd3,
		A_CBLINK = 3'd4,
		A_LED    = 3'd5,
		A_PUT    = 3'd6
	} action_t;

	typedef enum logic [1:0] {
		CS_IDLE,
		CS_ONE,
		CS_GOTO,
		CS_PUT
	} ctrl_state_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;
		logic load_one;
		logic load_goto;
		logic load_put;
	} slcp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic has_one;
		logic has_flush;
		logic out_free;
		logic put_last;
	} slcp_sts_t;

	// high-byte to display code map, first match of the source table wins
	function automatic logic [7:0] subst(input logic [7:0] c);
		logic [7:0] r;
		case (c)
			8'hE4: r = 8'hE1;
			8'hF6: r = 8'hEF;
			8'hFC: r = 8'hF5;
			8'hDF: r = 8'hE2;
			8'd248: r = 8'h30;
			8'd192, 8'd193, 8'd194, 8'd195, 8'd196, 8'd197, 8'd198: r = 8'h41;
			8'd199: r = 8'h43;
			8'd200, 8'd201, 8'd202, 8'd203: r = 8'h45;
			8'd204, 8'd205, 8'd206, 8'd207: r = 8'h49;
			8'd208: r = 8'h44;
			8'd209: r = 8'hEE;
			8'd210, 8'd211, 8'd212, 8'd213: r = 8'h4F;
			8'd214, 8'd216: r = 8'hEF;
			8'd217, 8'd218, 8'd219: r = 8'h55;
			8'd220: r = 8'hF5;
			8'd221: r = 8'h59;
			8'd224, 8'd225, 8'd226, 8'd227, 8'd229, 8'd230: r = 8'h61;
			8'd231: r = 8'h63;
			8'd232, 8'd233, 8'd234, 8'd235: r = 8'h65;
			8'd236, 8'd237, 8'd238, 8'd239: r = 8'h69;
			8'd240: r = 8'h6F;
			8'd241: r = 8'hEE;
			8'd242, 8'd243, 8'd244, 8'd245: r = 8'h6F;
			8'd247: r = 8'hFD;
			8'd249, 8'd250, 8'd251: r = 8'h75;
			8'd253, 8'd255: r = 8'h79;
			default: r = NO_MATCH;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/serial_lcd_command_parser_unit.sv =====
// Serial LCD command parser, top level. A byte is taken in one beat; a single
// result (hello, clear, goto, cursor, led) is loaded into the output register
// from the controller's CS_ONE state once the output is free. A line flush gives
// goto then LINE_LENGTH put_char beats, one per cycle while m_tready keeps the
// output free; s_tready stays low until the last result of a byte is loaded.
// Reset (arst_n low, async): parser waits for STX, line buffer reads as spaces.
`default_nettype none

module serial_lcd_command_parser_unit
	import slcp_pkg::*;
#(
	parameter int LINE_LENGTH = LINE_LENGTH_DEF   // display line, 8..40
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input stream: one received byte per beat
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
	// result stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,   // [2:0] action, [7:3] column, [9:8] row,
	                                    // [12:10] led_code, [20:13] char_code, zero pad
	output logic             m_tlast    // last result caused by the byte
);

	slcp_cmd_t  cmd;
	slcp_sts_t  sts;
	logic [2:0] action;
	logic [4:0] column;
	logic [1:0] row;
	logic [2:0] led_code;
	logic [7:0] char_code;

	// FSM: accept, then sequence single result or the flush beats
	slcp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// decode, parse state, line buffer and output register
	slcp_dp #(
		.LINE_LENGTH (LINE_LENGTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_byte   (s_tdata),
		.cmd       (cmd),
		.sts       (sts),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.action    (action),
		.column    (column),
		.row       (row),
		.led_code  (led_code),
		.char_code (char_code),
		.last      (m_tlast)
	);

	assign m_tdata = {3'b000, char_code, led_code, row, column, action};

endmodule

`default_nettype wire

// ===== hw/rtl/slcp_ctrl.sv =====
// Controller FSM of the serial LCD command parser: byte accept and result
// sequencing (single result, or goto plus line of put_char beats).
// Depends on slcp_pkg.
`default_nettype none

module slcp_ctrl
	import slcp_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      s_tvalid,
	output logic           s_tready,
	input  wire slcp_sts_t sts,
	output slcp_cmd_t      cmd
);

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			CS_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					if (sts.has_flush)    state_d = CS_GOTO;
					else if (sts.has_one) state_d = CS_ONE;
				end
			end
			CS_ONE: begin
				if (sts.out_free) begin
					cmd.load_one = 1'b1;
					state_d      = CS_IDLE;
				end
			end
			CS_GOTO: begin
				if (sts.out_free) begin
					cmd.load_goto = 1'b1;
					state_d       = CS_PUT;
				end
			end
			CS_PUT: begin
				if (sts.out_free) begin
					cmd.load_put = 1'b1;
					if (sts.put_last) state_d = CS_IDLE;
				end
			end
			default: state_d = CS_IDLE;
		endcase
	end

endmodule

`default_nettype wire

// ===== hw/rtl/slcp_dp.sv =====
// Datapath of the serial LCD command parser: byte decode, parse registers,
// line buffer memory with valid bits, pending result and output register.
// Depends on slcp_pkg.
`default_nettype none

module slcp_dp
	import slcp_pkg::*;
#(
	parameter int LINE_LENGTH = LINE_LENGTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [7:0]  rx_byte,
	input  wire slcp_cmd_t   cmd,
	output slcp_sts_t        sts,
	input  wire logic        out_ready,
	output logic             out_valid,
	output logic [2:0]       action,
	output logic [4:0]       column,
	output logic [1:0]       row,
	output logic [2:0]       led_code,
	output logic [7:0]       char_code,
	output logic             last
);

	localparam int FILL_W = $clog2(LINE_LENGTH + 1);
	localparam int IDX_W  = $clog2(LINE_LENGTH);
	localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(LINE_LENGTH - 1);
	localparam logic [FILL_W-1:0] FULL_CNT = FILL_W'(LINE_LENGTH);

	// parse registers
	mode_t             mode_q, mode_d;
	logic [1:0]        text_row_q, text_row_d;
	logic [FILL_W-1:0] fill_q, fill_d;
	logic [6:0]        col_tens_q, col_tens_d;
	logic [3:0]        col_ones_q, col_ones_d;

	// line buffer
	logic [7:0]             mem [LINE_LENGTH];
	logic [LINE_LENGTH-1:0] vld_q;
	logic [7:0]             rd_q;
	logic                   rd_vld_q;
	logic [IDX_W-1:0]       idx_q;
	logic                   rd_en;
	logic [IDX_W-1:0]       rd_addr;
	logic                   wr_en;

	// pending single result
	logic [2:0] pend_act_q, one_act;
	logic [4:0] pend_col_q, one_col;
	logic [1:0] pend_row_q, one_row;
	logic [2:0] pend_led_q, one_led;
	logic       one_vld, flush;

	logic [7:0] d;
	logic [7:0] txt;
	logic [7:0] col_sum;

	assign d       = rx_byte - CH_ZERO;
	assign txt     = (rx_byte > ASCII_MAX) ? subst(rx_byte) : rx_byte;
	assign col_sum = 8'(col_tens_q) + 8'(col_ones_q);

	always_comb begin
		mode_d     = M_STX;
		text_row_d = text_row_q;
		fill_d     = fill_q;
		col_tens_d = col_tens_q;
		col_ones_d = col_ones_q;
		one_vld    = 1'b0;
		one_act    = A_HELLO;
		one_col    = '0;
		one_row    = '0;
		one_led    = '0;
		flush      = 1'b0;
		wr_en      = 1'b0;

		// 'h' never causes a second result in any non-text mode
		if (mode_q != M_TEXT && rx_byte == CH_HELLO) begin
			one_vld = 1'b1;
		end

		case (mode_q)
			M_CMD: begin
				if (rx_byte == CH_Z)      mode_d = M_ROW;
				else if (rx_byte == CH_L) mode_d = M_LED;
				else if (rx_byte == CH_C) mode_d = M_CUREN;
				else if (rx_byte == CH_M) mode_d = M_COL1;
				else if (rx_byte == CH_S) mode_d = M_SS;
			end
			M_SS: begin
				if (rx_byte == CH_S) begin
					one_vld = 1'b1;
					one_act = A_CLEAR;
				end
			end
			M_COL1: begin
				if (d > 8'd9) begin
					col_tens_d = '0;
				end else begin
					col_tens_d = 7'({d[3:0], 3'b000} + {3'b000, d[3:0], 1'b0});
					mode_d     = M_COL2;
				end
			end
			M_COL2: begin
				if (d > 8'd9 || (8'(col_tens_q) + d) > COL_MAX) begin
					col_tens_d = '0;
					col_ones_d = '0;
				end else begin
					col_ones_d = d[3:0];
					mode_d     = M_SEP;
				end
			end
			M_SEP: begin
				if (rx_byte == CH_PIPE) begin
					mode_d = M_CROW;
				end else begin
					col_tens_d = '0;
					col_ones_d = '0;
				end
			end
			M_CROW: begin
				if (d <= 8'd3) begin
					one_vld = 1'b1;
					one_act = A_GOTO;
					one_col = col_sum[4:0];
					one_row = d[1:0];
				end
				col_tens_d = '0;
				col_ones_d = '0;
			end
			M_CUREN: begin
				if (rx_byte == CH_ZERO) begin
					one_vld = 1'b1;
					one_act = A_COFF;
				end else if (rx_byte == CH_ONE) begin
					one_vld = 1'b1;
					one_act = A_CBLINK;
				end
			end
			M_LED: begin
				if (d <= 8'd7) begin
					one_vld = 1'b1;
					one_act = A_LED;
					one_led = d[2:0];
				end
			end
			M_ROW: begin
				if (d <= 8'd3) begin
					text_row_d = d[1:0];
					mode_d     = M_SPACE;
				end
			end
			M_SPACE: begin
				if (rx_byte == CH_SPACE) mode_d = M_TEXT;
				else                     text_row_d = '0;
			end
			M_TEXT: begin
				if (rx_byte == CH_ETX || fill_q >= FULL_CNT) begin
					flush  = 1'b1;
					fill_d = '0;
				end else begin
					wr_en  = 1'b1;
					fill_d = fill_q + 1'b1;
					mode_d = M_TEXT;
				end
			end
			default: begin
				if (rx_byte == CH_STX) mode_d = M_CMD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= M_STX;
			text_row_q <= '0;
			fill_q     <= '0;
			col_tens_q <= '0;
			col_ones_q <= '0;
		end else if (cmd.accept) begin
			mode_q     <= mode_d;
			text_row_q <= text_row_d;
			fill_q     <= fill_d;
			col_tens_q <= col_tens_d;
			col_ones_q <= col_ones_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			pend_act_q <= one_act;
			pend_col_q <= one_col;
			pend_row_q <= one_row;
			pend_led_q <= one_led;
		end
	end

	// buffer memory: write on text byte, registered read for flush
	always_ff @(posedge clk) begin
		if (cmd.accept && wr_en) begin
			mem[fill_q[IDX_W-1:0]] <= txt;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// read prefetch: entry 0 with the goto beat, next entry with each put beat but the last
	assign rd_en   = cmd.load_goto || (cmd.load_put && idx_q != LAST_IDX);
	assign rd_addr = cmd.load_goto ? '0 : idx_q + 1'b1;

	// unwritten entries read as space; all cleared after the last put
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
			idx_q    <= '0;
		end else begin
			if (cmd.accept && wr_en) begin
				vld_q[fill_q[IDX_W-1:0]] <= 1'b1;
			end else if (cmd.load_put && idx_q == LAST_IDX) begin
				vld_q <= '0;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
			if (cmd.load_goto) begin
				idx_q <= '0;
			end else if (cmd.load_put && idx_q != LAST_IDX) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.load_one || cmd.load_goto || cmd.load_put) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_one) begin
			action    <= pend_act_q;
			column    <= pend_col_q;
			row       <= pend_row_q;
			led_code  <= pend_led_q;
			char_code <= '0;
			last      <= 1'b1;
		end else if (cmd.load_goto) begin
			action    <= A_GOTO;
			column    <= '0;
			row       <= text_row_q;
			led_code  <= '0;
			char_code <= '0;
			last      <= 1'b0;
		end else if (cmd.load_put) begin
			action    <= A_PUT;
			column    <= '0;
			row       <= '0;
			led_code  <= '0;
			char_code <= rd_vld_q ? rd_q : CH_SPACE;
			last      <= (idx_q == LAST_IDX);
		end
	end

	assign sts.has_one   = one_vld;
	assign sts.has_flush = flush;
	assign sts.out_free  = !out_valid || out_ready;
	assign sts.put_last  = (idx_q == LAST_IDX);

endmodule

`default_nettype wire
